### hw/rtl/ipvl_pkg.sv
// ----------------------------------------------------------------------------
// ipvl_pkg
// Types and constants for the incremental PI velocity loop: word layouts,
// register indexes and reset values, fixed-point limits and the saturation
// helper.
// ----------------------------------------------------------------------------
package ipvl_pkg;

   localparam int MOTORS_DEFAULT = 4;

   localparam int SPEED_W   = 24;
   localparam int PWM_W     = 15;
   localparam int GAIN_W    = 16;
   localparam int ALPHA_W   = 9;
   localparam int ILIM_W    = 23;
   localparam int STALL_W   = 5;
   localparam int COOL_W    = 6;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_W     = 23;

   // serial multiplier: accumulator width and one multiplier bit per cycle
   localparam int ACC_W     = 42;
   localparam int MUL_STEPS = GAIN_W;
   localparam int MUL_CNT_W = $clog2(MUL_STEPS);
   localparam int QUOT_W    = ACC_W - 16;
   localparam int SUM_W     = QUOT_W + 1;
   localparam int MAG_W     = SPEED_W;

   localparam logic [CSR_IDX_W-1:0] REG_PROP_GAIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_GAIN   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_FILTER_ALPHA    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SPEED_PER_PULSE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_PWM_MAX         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_STALL_PWM_LEVEL = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_DEADZONE_PWM    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_INTEGRAL_LIMIT  = 3'd7;

   localparam logic [GAIN_W-1:0]  RST_PROP_GAIN       = 16'd256;
   localparam logic [GAIN_W-1:0]  RST_INTEGRAL_GAIN   = 16'd26;
   localparam logic [ALPHA_W-1:0] RST_FILTER_ALPHA    = 9'd205;
   localparam logic [GAIN_W-1:0]  RST_SPEED_PER_PULSE = 16'd3592;
   localparam logic [PWM_W-1:0]   RST_PWM_MAX         = 15'd999;
   localparam logic [PWM_W-1:0]   RST_STALL_PWM_LEVEL = 15'd999;
   localparam logic [PWM_W-1:0]   RST_DEADZONE_PWM    = 15'd200;
   localparam logic [ILIM_W-1:0]  RST_INTEGRAL_LIMIT  = 23'd20480;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_ESTOP  = 1'b1;

   localparam logic [1:0] DIR_STOP = 2'd0;
   localparam logic [1:0] DIR_FWD  = 2'd1;
   localparam logic [1:0] DIR_REV  = 2'd2;

   localparam logic [ALPHA_W-1:0]        ALPHA_FULL      = 9'd256;
   localparam logic [MAG_W-1:0]          DEADZONE_TARGET = 24'd3840;
   localparam logic signed [SPEED_W-1:0] STALL_SPEED_HI  = 24'sd2048;
   localparam logic signed [SPEED_W-1:0] STALL_SPEED_LO  = -24'sd2048;
   localparam logic [STALL_W-1:0]        STALL_TRIP      = 5'd25;
   localparam logic [COOL_W-1:0]         COOLDOWN_LEN    = 6'd50;
   localparam logic signed [ACC_W-1:0]   SPEED_MAX       = 42'sd8388607;
   localparam logic signed [ACC_W-1:0]   SPEED_MIN       = -42'sd8388608;
   localparam logic signed [ACC_W-1:0]   TRUNC_BIAS      = 42'sd65535;

   typedef struct packed {
      logic                      opcode;
      logic [1:0]                motor;
      logic signed [15:0]        pulses;
      logic signed [SPEED_W-1:0] set_speed;
   } req_word_type;

   typedef struct packed {
      logic [1:0]                motor_out;
      logic [PWM_W-1:0]          pwm_duty;
      logic [1:0]                direction;
      logic signed [SPEED_W-1:0] filtered_speed;
      logic                      cooling_down;
   } rsp_word_type;

   function automatic logic signed [SPEED_W-1:0] sat_speed(
      input logic signed [ACC_W-1:0] x);
      logic signed [ACC_W-1:0] y;
      y = x;
      if (x > SPEED_MAX) begin
         y = SPEED_MAX;
      end else if (x < SPEED_MIN) begin
         y = SPEED_MIN;
      end
      return y[SPEED_W-1:0];
   endfunction

endpackage

### hw/rtl/incremental_pi_velocity_loop.sv
// ----------------------------------------------------------------------------
// incremental_pi_velocity_loop
// Per-motor speed filter and incremental PI loop with anti-windup, start-up
// deadzone and stall cutoff; all products share one bit-serial multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request word: an update for one motor or an emergency
//   stop for all motors. rsp_* returns exactly one result word per request.
//   csr_* writes the gain and limit registers; write only while idle.
//   An update runs five shift-add products on the shared multiplier (pulse
//   speed, two filter terms, integral, proportional) plus five steps (error,
//   two duty steps, finish, output). rsp_valid rises as the output step hands
//   the word on and req_stall drops at the same edge, so a new update is taken
//   only after the previous one has been answered. Stop requests and updates
//   naming a motor index of MOTORS or more go straight to the output step.
//   req_stall is high while a request is in progress. A result waiting under
//   rsp_stall does not block the next request; that one finishes and holds in
//   its final step until the output register frees.
//   Reset (synchronous) restores the register defaults and clears all
//   per-motor state and any pending word.
// ----------------------------------------------------------------------------
module incremental_pi_velocity_loop
   import ipvl_pkg::*;
#(
   parameter int MOTORS = MOTORS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_word_type         req_word,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_word_type         rsp_word,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_data
);

   localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;

   typedef enum logic [10:0] {
      S_IDLE  = 11'b000_0000_0001,
      S_INST  = 11'b000_0000_0010,
      S_FILT1 = 11'b000_0000_0100,
      S_FILT2 = 11'b000_0000_1000,
      S_ERR   = 11'b000_0001_0000,
      S_INTG  = 11'b000_0010_0000,
      S_PROP  = 11'b000_0100_0000,
      S_PWM1  = 11'b000_1000_0000,
      S_PWM2  = 11'b001_0000_0000,
      S_FIN   = 11'b010_0000_0000,
      S_OUT   = 11'b100_0000_0000
   } state_type;

   // configuration
   logic [GAIN_W-1:0]  kp_ff, ki_ff, spp_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [PWM_W-1:0]   pwm_max_ff, stall_lvl_ff, dz_ff;
   logic [ILIM_W-1:0]  ilim_ff;

   // per-motor state
   logic signed [SPEED_W-1:0] speed_est_ff [MOTORS];
   logic signed [SPEED_W-1:0] speed_est_in [MOTORS];
   logic signed [SPEED_W-1:0] prev_err_ff  [MOTORS];
   logic signed [SPEED_W-1:0] prev_err_in  [MOTORS];
   logic [PWM_W-1:0]          duty_ff      [MOTORS];
   logic [PWM_W-1:0]          duty_in      [MOTORS];
   logic [STALL_W-1:0]        stall_cnt_ff [MOTORS];
   logic [STALL_W-1:0]        stall_cnt_in [MOTORS];
   logic [COOL_W-1:0]         cool_left_ff [MOTORS];
   logic [COOL_W-1:0]         cool_left_in [MOTORS];

   // sequencer and datapath
   state_type                 state_ff, state_in;
   logic [MW-1:0]             m_ff, m_in;
   logic [1:0]                motor_ff, motor_in;
   logic signed [SPEED_W-1:0] target_ff, target_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [ACC_W-1:0]   mcand_ff, mcand_in;
   logic [GAIN_W-1:0]         mplier_ff, mplier_in;
   logic [MUL_CNT_W-1:0]      cnt_ff, cnt_in;
   logic signed [SPEED_W-1:0] speed_ff, speed_in;
   logic signed [SPEED_W-1:0] err_ff, err_in;
   logic [MAG_W-1:0]          mag_ff, mag_in;
   logic signed [ACC_W-1:0]   iterm_ff, iterm_in;
   logic [PWM_W-1:0]          pwm_ff, pwm_in;
   rsp_word_type              pend_ff, pend_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_word_ff, rsp_word_in;

   // combinational temporaries
   logic signed [ACC_W-1:0]   acc_sum;
   logic                      mul_last;
   logic [ALPHA_W-1:0]        alpha_c, alpha_inv;
   logic signed [SPEED_W-1:0] cur_speed, cur_prev;
   logic [PWM_W-1:0]          cur_duty;
   logic [STALL_W-1:0]        cur_sc, sc_inc;
   logic [COOL_W-1:0]         cur_cd;
   logic signed [SPEED_W+1:0] tgt_ext, mag_w, diff_w;
   logic signed [SPEED_W-1:0] err_w;
   logic signed [ACC_W-1:0]   ilim_pos, ilim_neg, delta, biased, shifted;
   logic                      windup;
   logic signed [QUOT_W-1:0]  quot;
   logic signed [SUM_W-1:0]   duty_sum;
   logic [PWM_W-1:0]          pwm_dz, pwm_fin;
   logic                      cool;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   always_comb begin
      acc_sum   = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
      mul_last  = (cnt_ff == MUL_CNT_W'(MUL_STEPS - 1));
      alpha_c   = (alpha_ff > ALPHA_FULL) ? ALPHA_FULL : alpha_ff;
      alpha_inv = ALPHA_FULL - alpha_c;
      cur_speed = speed_est_ff[m_ff];
      cur_prev  = prev_err_ff[m_ff];
      cur_duty  = duty_ff[m_ff];
      cur_sc    = stall_cnt_ff[m_ff];
      cur_cd    = cool_left_ff[m_ff];
      sc_inc    = cur_sc + STALL_W'(1);

      tgt_ext = (SPEED_W+2)'(target_ff);
      mag_w   = tgt_ext[SPEED_W+1] ? -tgt_ext : tgt_ext;
      diff_w  = mag_w - (SPEED_W+2)'(speed_ff);
      err_w   = sat_speed(ACC_W'(diff_w));

      ilim_pos = ACC_W'({ilim_ff, 8'd0});
      ilim_neg = -ilim_pos;

      delta  = acc_ff + iterm_ff;
      windup = ((cur_duty >= pwm_max_ff) && !delta[ACC_W-1] && (delta != '0)) ||
               ((cur_duty == '0) && delta[ACC_W-1]);

      biased   = acc_ff + (acc_ff[ACC_W-1] ? TRUNC_BIAS : '0);
      shifted  = biased >>> 16;
      quot     = shifted[QUOT_W-1:0];
      duty_sum = SUM_W'(quot) + SUM_W'({1'b0, cur_duty});

      pwm_dz = pwm_ff;
      if ((mag_ff > DEADZONE_TARGET) && (pwm_ff != '0) && (pwm_ff < dz_ff)) begin
         pwm_dz = (dz_ff < pwm_max_ff) ? dz_ff : pwm_max_ff;
      end

      state_in     = state_ff;
      m_in         = m_ff;
      motor_in     = motor_ff;
      target_in    = target_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      cnt_in       = cnt_ff;
      speed_in     = speed_ff;
      err_in       = err_ff;
      mag_in       = mag_ff;
      iterm_in     = iterm_ff;
      pwm_in       = pwm_ff;
      pend_in      = pend_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      speed_est_in = speed_est_ff;
      prev_err_in  = prev_err_ff;
      duty_in      = duty_ff;
      stall_cnt_in = stall_cnt_ff;
      cool_left_in = cool_left_ff;
      pwm_fin      = pwm_dz;
      cool         = 1'b0;

      if ((state_ff == S_INST) || (state_ff == S_FILT1) || (state_ff == S_FILT2) ||
          (state_ff == S_INTG) || (state_ff == S_PROP)) begin
         acc_in    = acc_sum;
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         cnt_in    = cnt_ff + MUL_CNT_W'(1);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               target_in = req_word.set_speed;
               motor_in  = req_word.motor;
               m_in      = MW'(req_word.motor);
               pend_in   = '0;
               if (req_word.opcode == OP_ESTOP) begin
                  for (int i = 0; i < MOTORS; i++) begin
                     duty_in[i]      = '0;
                     prev_err_in[i]  = '0;
                     stall_cnt_in[i] = '0;
                  end
                  state_in = S_OUT;
               end else if (int'(req_word.motor) >= MOTORS) begin
                  pend_in.motor_out = req_word.motor;
                  state_in          = S_OUT;
               end else begin
                  acc_in    = '0;
                  mcand_in  = ACC_W'(req_word.pulses);
                  mplier_in = spp_ff;
                  cnt_in    = '0;
                  state_in  = S_INST;
               end
            end
         end
         S_INST: begin
            if (mul_last) begin
               acc_in    = '0;
               mcand_in  = acc_sum;
               mplier_in = GAIN_W'(alpha_c);
               cnt_in    = '0;
               state_in  = S_FILT1;
            end
         end
         S_FILT1: begin
            if (mul_last) begin
               mcand_in  = ACC_W'(cur_speed);
               mplier_in = GAIN_W'(alpha_inv);
               cnt_in    = '0;
               state_in  = S_FILT2;
            end
         end
         S_FILT2: begin
            if (mul_last) begin
               speed_in = sat_speed(acc_sum >>> 8);
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            err_in    = err_w;
            mag_in    = mag_w[MAG_W-1:0];
            acc_in    = '0;
            mcand_in  = ACC_W'(err_w);
            mplier_in = ki_ff;
            cnt_in    = '0;
            state_in  = S_INTG;
         end
         S_INTG: begin
            if (mul_last) begin
               iterm_in  = acc_sum;
               acc_in    = '0;
               mcand_in  = ACC_W'(err_ff) - ACC_W'(cur_prev);
               mplier_in = kp_ff;
               cnt_in    = '0;
               state_in  = S_PROP;
            end
         end
         S_PROP: begin
            if (cnt_ff == '0) begin
               if (iterm_ff > ilim_pos) begin
                  iterm_in = ilim_pos;
               end else if (iterm_ff < ilim_neg) begin
                  iterm_in = ilim_neg;
               end
            end
            if (mul_last) begin
               state_in = S_PWM1;
            end
         end
         S_PWM1: begin
            acc_in   = windup ? acc_ff : delta;
            state_in = S_PWM2;
         end
         S_PWM2: begin
            if (duty_sum[SUM_W-1]) begin
               pwm_in = '0;
            end else if (duty_sum > SUM_W'({1'b0, pwm_max_ff})) begin
               pwm_in = pwm_max_ff;
            end else begin
               pwm_in = duty_sum[PWM_W-1:0];
            end
            state_in = S_FIN;
         end
         S_FIN: begin
            if (cur_cd != '0) begin
               cool_left_in[m_ff] = cur_cd - COOL_W'(1);
               pwm_fin            = '0;
               cool               = 1'b1;
            end else if ((pwm_dz >= stall_lvl_ff) && (speed_ff < STALL_SPEED_HI) &&
                         (speed_ff > STALL_SPEED_LO)) begin
               if (sc_inc >= STALL_TRIP) begin
                  stall_cnt_in[m_ff] = '0;
                  cool_left_in[m_ff] = COOLDOWN_LEN;
                  pwm_fin            = '0;
                  cool               = 1'b1;
               end else begin
                  stall_cnt_in[m_ff] = sc_inc;
               end
            end else begin
               stall_cnt_in[m_ff] = '0;
            end
            speed_est_in[m_ff] = speed_ff;
            prev_err_in[m_ff]  = err_ff;
            duty_in[m_ff]      = pwm_fin;

            pend_in.motor_out      = motor_ff;
            pend_in.pwm_duty       = pwm_fin;
            pend_in.filtered_speed = speed_ff;
            pend_in.cooling_down   = cool;
            if (target_ff[SPEED_W-1]) begin
               pend_in.direction = DIR_REV;
            end else if (target_ff != '0) begin
               pend_in.direction = DIR_FWD;
            end else begin
               pend_in.direction = DIR_STOP;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = pend_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff        <= RST_PROP_GAIN;
         ki_ff        <= RST_INTEGRAL_GAIN;
         alpha_ff     <= RST_FILTER_ALPHA;
         spp_ff       <= RST_SPEED_PER_PULSE;
         pwm_max_ff   <= RST_PWM_MAX;
         stall_lvl_ff <= RST_STALL_PWM_LEVEL;
         dz_ff        <= RST_DEADZONE_PWM;
         ilim_ff      <= RST_INTEGRAL_LIMIT;
      end else if (csr_write) begin
         case (csr_index)
            REG_PROP_GAIN:       kp_ff        <= csr_data[GAIN_W-1:0];
            REG_INTEGRAL_GAIN:   ki_ff        <= csr_data[GAIN_W-1:0];
            REG_FILTER_ALPHA:    alpha_ff     <= csr_data[ALPHA_W-1:0];
            REG_SPEED_PER_PULSE: spp_ff       <= csr_data[GAIN_W-1:0];
            REG_PWM_MAX:         pwm_max_ff   <= csr_data[PWM_W-1:0];
            REG_STALL_PWM_LEVEL: stall_lvl_ff <= csr_data[PWM_W-1:0];
            REG_DEADZONE_PWM:    dz_ff        <= csr_data[PWM_W-1:0];
            REG_INTEGRAL_LIMIT:  ilim_ff      <= csr_data[ILIM_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < MOTORS; i++) begin
            speed_est_ff[i] <= '0;
            prev_err_ff[i]  <= '0;
            duty_ff[i]      <= '0;
            stall_cnt_ff[i] <= '0;
            cool_left_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         speed_est_ff <= speed_est_in;
         prev_err_ff  <= prev_err_in;
         duty_ff      <= duty_in;
         stall_cnt_ff <= stall_cnt_in;
         cool_left_ff <= cool_left_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff        <= m_in;
      motor_ff    <= motor_in;
      target_ff   <= target_in;
      acc_ff      <= acc_in;
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      cnt_ff      <= cnt_in;
      speed_ff    <= speed_in;
      err_ff      <= err_in;
      mag_ff      <= mag_in;
      iterm_ff    <= iterm_in;
      pwm_ff      <= pwm_in;
      pend_ff     <= pend_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule
